@@ hdl/ggbs_pkg.sv @@
package ggbs_pkg;

  localparam int TURN_Q16 = 23592960;
  localparam int HALF_Q = 32768;

  localparam int DIV_N = 41;
  localparam int DIV_D = 25;
  localparam int MOD_N = 25;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW = 2;
  localparam int QUEUE_CW = 3;

  localparam logic signed [23:0] SOUTH_RESET = -24'sd5898240;
  localparam logic signed [25:0] WEST_RESET = -26'sd11796480;
  localparam logic [23:0] ROW_STEP_RESET = 24'd65536;
  localparam logic [24:0] COLUMN_STEP_RESET = 25'd65536;
  localparam logic [6:0] ROW_COUNT_RESET = 7'd64;
  localparam logic [6:0] COLUMN_COUNT_RESET = 7'd64;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef enum logic [2:0] {
    REG_SOUTH_LATITUDE = 3'd0,
    REG_WEST_LONGITUDE = 3'd1,
    REG_ROW_STEP = 3'd2,
    REG_COLUMN_STEP = 3'd3,
    REG_ROW_COUNT = 3'd4,
    REG_COLUMN_COUNT = 3'd5,
    REG_GLOBAL_WRAP = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic signed [23:0] south_latitude;
    logic signed [25:0] west_longitude;
    logic [23:0] row_step;
    logic [24:0] column_step;
    logic [6:0] row_count;
    logic [6:0] column_count;
    logic global_wrap;
  } cfg_t;

  typedef struct packed {
    logic mode;
    logic [11:0] sample_index;
    logic signed [31:0] sample_value;
    logic found;
  } pl_t;

  typedef struct packed {
    pl_t pl;
    logic [23:0] dlat;
    logic [24:0] dlon;
  } item_t;

  typedef struct packed {
    logic found;
    logic signed [31:0] blended_value;
    logic [5:0] base_row;
    logic [5:0] base_column;
    logic [16:0] row_fraction;
    logic [16:0] column_fraction;
  } res_t;

endpackage

@@ hdl/geo_grid_bilinear_sampler.sv @@
// done pulses after a query passes the front, queue, dividers, store and blend.
// Throughput: one item per cycle; busy stays low in normal use and results
// cannot be held off by the receiver.
// The rate is set by the bit-per-stage pipelined dividers and four store copies.
// Reset (rst, synchronous): clears control and loads register defaults;
// the sample store is undefined until written.
module geo_grid_bilinear_sampler #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLUMNS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               mode,
  input  logic [11:0]        sample_index,
  input  logic signed [31:0] sample_value,
  input  logic signed [23:0] query_latitude,
  input  logic signed [25:0] query_longitude,
  output logic               done,
  output logic               found,
  output logic signed [31:0] blended_value,
  output logic [5:0]         base_row,
  output logic [5:0]         base_column,
  output logic [16:0]        row_fraction,
  output logic [16:0]        column_fraction,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [25:0]        cfg_data
);

  localparam int RCW = $clog2(MAX_ROWS + 1);
  localparam int CCW = $clog2(MAX_COLUMNS + 1);

  ggbs_pkg::cfg_t cfg;
  logic [RCW-1:0] rows_eff;
  logic [CCW-1:0] cols_eff;
  logic [23:0] rstep_eff;
  logic [24:0] cstep_eff;
  logic accept;
  logic push;
  ggbs_pkg::item_t push_item;
  logic q_valid;
  ggbs_pkg::item_t q_item;
  ggbs_pkg::res_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.south_latitude <= ggbs_pkg::SOUTH_RESET;
      cfg.west_longitude <= ggbs_pkg::WEST_RESET;
      cfg.row_step <= ggbs_pkg::ROW_STEP_RESET;
      cfg.column_step <= ggbs_pkg::COLUMN_STEP_RESET;
      cfg.row_count <= ggbs_pkg::ROW_COUNT_RESET;
      cfg.column_count <= ggbs_pkg::COLUMN_COUNT_RESET;
      cfg.global_wrap <= 1'b0;
    end else if (cfg_write) begin
      unique case (ggbs_pkg::cfg_reg_t'(cfg_index))
        ggbs_pkg::REG_SOUTH_LATITUDE: cfg.south_latitude <= cfg_data[23:0];
        ggbs_pkg::REG_WEST_LONGITUDE: cfg.west_longitude <= cfg_data;
        ggbs_pkg::REG_ROW_STEP:       cfg.row_step <= cfg_data[23:0];
        ggbs_pkg::REG_COLUMN_STEP:    cfg.column_step <= cfg_data[24:0];
        ggbs_pkg::REG_ROW_COUNT:      cfg.row_count <= cfg_data[6:0];
        ggbs_pkg::REG_COLUMN_COUNT:   cfg.column_count <= cfg_data[6:0];
        ggbs_pkg::REG_GLOBAL_WRAP:    cfg.global_wrap <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (cfg.row_count < 7'd2) begin
      rows_eff = RCW'(2);
    end else if (32'(cfg.row_count) > MAX_ROWS) begin
      rows_eff = RCW'(MAX_ROWS);
    end else begin
      rows_eff = RCW'(cfg.row_count);
    end
    if (cfg.column_count < 7'd2) begin
      cols_eff = CCW'(2);
    end else if (32'(cfg.column_count) > MAX_COLUMNS) begin
      cols_eff = CCW'(MAX_COLUMNS);
    end else begin
      cols_eff = CCW'(cfg.column_count);
    end
    rstep_eff = (cfg.row_step == '0) ? 24'd1 : cfg.row_step;
    cstep_eff = (cfg.column_step == '0) ? 25'd1 : cfg.column_step;
  end

  assign accept = start && !busy;

  ggbs_front #(.MAX_ROWS(MAX_ROWS), .MAX_COLUMNS(MAX_COLUMNS)) u_front (
    .clk             (clk),
    .rst             (rst),
    .accept          (accept),
    .mode            (mode),
    .sample_index    (sample_index),
    .sample_value    (sample_value),
    .query_latitude  (query_latitude),
    .query_longitude (query_longitude),
    .cfg             (cfg),
    .rows            (rows_eff),
    .cols            (cols_eff),
    .rstep           (rstep_eff),
    .cstep           (cstep_eff),
    .push            (push),
    .push_item       (push_item)
  );

  ggbs_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .busy      (busy)
  );

  ggbs_back #(.MAX_ROWS(MAX_ROWS), .MAX_COLUMNS(MAX_COLUMNS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .rows        (rows_eff),
    .cols        (cols_eff),
    .rstep       (rstep_eff),
    .cstep       (cstep_eff),
    .global_wrap (cfg.global_wrap),
    .done        (done),
    .res         (res)
  );

  assign found = res.found;
  assign blended_value = res.blended_value;
  assign base_row = res.base_row;
  assign base_column = res.base_column;
  assign row_fraction = res.row_fraction;
  assign column_fraction = res.column_fraction;

`ifndef ASSERT_OFF
  a_frac_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (row_fraction <= 17'd65536 && column_fraction <= 17'd65536))
    else $error("cell fraction above one");
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !found) |-> (blended_value == '0 && base_row == '0 && base_column == '0))
    else $error("miss result not zeroed");
  a_found_strobe: assert property (@(posedge clk) disable iff (rst)
    found |-> done)
    else $error("found without result strobe");
`endif

endmodule

@@ hdl/ggbs_div.sv @@
module ggbs_div #(
  parameter int N = 41,
  parameter int D = 25
) (
  input  logic         clk,
  input  logic [N-1:0] dividend,
  input  logic [D-1:0] divisor,
  output logic [N-1:0] quotient,
  output logic [D-1:0] remainder
);

  logic [D-1:0] rem [1:N];
  logic [N-1:0] dq [1:N];
  logic [D-1:0] dv [1:N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [D-1:0] rem_in;
    logic [N-1:0] dq_in;
    logic [D-1:0] dv_in;
    logic [D:0] trial;
    logic ge;

    if (i == 0) begin : g_first
      assign rem_in = '0;
      assign dq_in = dividend;
      assign dv_in = divisor;
    end else begin : g_next
      assign rem_in = rem[i];
      assign dq_in = dq[i];
      assign dv_in = dv[i];
    end

    assign trial = {rem_in, dq_in[N-1]};
    assign ge = trial >= {1'b0, dv_in};

    always_ff @(posedge clk) begin
      rem[i+1] <= ge ? D'(trial - {1'b0, dv_in}) : trial[D-1:0];
      dq[i+1] <= {dq_in[N-2:0], ge};
      dv[i+1] <= dv_in;
    end
  end

  assign quotient = dq[N];
  assign remainder = rem[N];

endmodule

@@ hdl/ggbs_front.sv @@
module ggbs_front #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLUMNS = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                accept,
  input  logic                                mode,
  input  logic [11:0]                         sample_index,
  input  logic signed [31:0]                  sample_value,
  input  logic signed [23:0]                  query_latitude,
  input  logic signed [25:0]                  query_longitude,
  input  ggbs_pkg::cfg_t                      cfg,
  input  logic [$clog2(MAX_ROWS+1)-1:0]       rows,
  input  logic [$clog2(MAX_COLUMNS+1)-1:0]    cols,
  input  logic [23:0]                         rstep,
  input  logic [24:0]                         cstep,
  output logic                                push,
  output ggbs_pkg::item_t                     push_item
);

  localparam int RCW = $clog2(MAX_ROWS + 1);
  localparam int CCW = $clog2(MAX_COLUMNS + 1);
  localparam int RLW = 24 + RCW;
  localparam int CLW = 25 + CCW;

  logic v1;
  logic m1;
  logic [11:0] i1;
  logic signed [31:0] s1;
  logic signed [24:0] dlat1;
  logic signed [26:0] dl1;
  logic [RLW-1:0] rlim1;
  logic [CLW-1:0] clim1;

  logic v2;
  logic m2;
  logic [11:0] i2;
  logic signed [31:0] s2;
  logic lat_ok2;
  logic [23:0] dlat2;
  logic [24:0] dlon2;
  logic [CLW-1:0] clim2;

  logic [24:0] dlon_sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    m1 <= mode;
    i1 <= sample_index;
    s1 <= sample_value;
    dlat1 <= 25'(query_latitude) - 25'(cfg.south_latitude);
    dl1 <= 27'(query_longitude) - 27'(cfg.west_longitude);
    rlim1 <= RLW'(rstep) * RLW'(rows - RCW'(1));
    clim1 <= CLW'(cstep) * CLW'(cols - CCW'(1));
  end

  always_comb begin
    logic signed [28:0] cand;
    dlon_sel = '0;
    for (int k = 0; k < 6; k++) begin
      cand = 29'(dl1) + 29'((k - 2) * ggbs_pkg::TURN_Q16);
      if (!cand[28] && cand < 29'(ggbs_pkg::TURN_Q16)) begin
        dlon_sel = cand[24:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    m2 <= m1;
    i2 <= i1;
    s2 <= s1;
    lat_ok2 <= !dlat1[24] && (RLW'(dlat1[23:0]) <= rlim1);
    dlat2 <= dlat1[23:0];
    dlon2 <= dlon_sel;
    clim2 <= clim1;
  end

  assign push = v2;

  always_comb begin
    push_item.pl.mode = m2;
    push_item.pl.sample_index = i2;
    push_item.pl.sample_value = s2;
    push_item.pl.found = lat_ok2 && (cfg.global_wrap || (CLW'(dlon2) <= clim2));
    push_item.dlat = dlat2;
    push_item.dlon = dlon2;
  end

endmodule

@@ hdl/ggbs_fifo.sv @@
module ggbs_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ggbs_pkg::item_t push_item,
  output logic            q_valid,
  output ggbs_pkg::item_t q_item,
  output logic            busy
);

  ggbs_pkg::item_t slots [ggbs_pkg::QUEUE_DEPTH];
  logic [ggbs_pkg::QUEUE_AW-1:0] wptr;
  logic [ggbs_pkg::QUEUE_AW-1:0] rptr;
  logic [ggbs_pkg::QUEUE_CW-1:0] count;
  logic pop;

  assign q_valid = count != '0;
  assign pop = q_valid;
  assign q_item = slots[rptr];
  assign busy = count >= ggbs_pkg::QUEUE_CW'(ggbs_pkg::QUEUE_DEPTH - 2);

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_item;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && !pop && count == ggbs_pkg::QUEUE_CW'(ggbs_pkg::QUEUE_DEPTH)))
    else $error("item queue overflow");
`endif

endmodule

@@ hdl/ggbs_back.sv @@
module ggbs_back #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLUMNS = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                q_valid,
  input  ggbs_pkg::item_t                     q_item,
  input  logic [$clog2(MAX_ROWS+1)-1:0]       rows,
  input  logic [$clog2(MAX_COLUMNS+1)-1:0]    cols,
  input  logic [23:0]                         rstep,
  input  logic [24:0]                         cstep,
  input  logic                                global_wrap,
  output logic                                done,
  output ggbs_pkg::res_t                      res
);

  localparam int RCW = $clog2(MAX_ROWS + 1);
  localparam int CCW = $clog2(MAX_COLUMNS + 1);
  localparam int RW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_COLUMNS);
  localparam int DEPTH = MAX_ROWS * MAX_COLUMNS;
  localparam int AW = $clog2(DEPTH);
  localparam int RO_W = RCW + 16;
  localparam int CO_W = CCW + 16;

  typedef struct packed {
    ggbs_pkg::pl_t pl;
    logic [RO_W-1:0] roff;
    logic [CO_W-1:0] coff;
  } bl_t;

  typedef struct packed {
    ggbs_pkg::pl_t pl;
    logic [RW-1:0] brow;
    logic [CW-1:0] bcol;
    logic [CW-1:0] ecol;
    logic [16:0] rfrac;
    logic [16:0] cfrac;
  } kt_t;

  logic [ggbs_pkg::DIV_N-1:0] quo_r;
  logic [ggbs_pkg::DIV_N-1:0] quo_c;
  logic [CCW-1:0] mod_rem;

  logic a_val [1:ggbs_pkg::DIV_N];
  ggbs_pkg::pl_t a_pl [1:ggbs_pkg::DIV_N];
  logic b_val [1:ggbs_pkg::MOD_N];
  bl_t b_d [1:ggbs_pkg::MOD_N];

  logic c_val;
  kt_t c_k;
  kt_t c_next;
  logic s_val;
  kt_t s_k;
  logic [AW-1:0] s_addr;
  logic [AW-1:0] n_addr;
  logic m_val;
  kt_t m_k;
  logic signed [31:0] rd_sw;
  logic signed [31:0] rd_se;
  logic signed [31:0] rd_nw;
  logic signed [31:0] rd_ne;
  logic l1_val;
  kt_t l1_k;
  logic signed [50:0] p_lo;
  logic signed [50:0] p_hi;
  logic signed [31:0] l1_sw;
  logic signed [31:0] l1_nw;
  logic l2_val;
  kt_t l2_k;
  logic signed [31:0] lower;
  logic signed [31:0] upper;
  logic l3_val;
  kt_t l3_k;
  logic signed [50:0] p_v;
  logic signed [31:0] l3_lower;

  logic signed [31:0] mem_sw [DEPTH];
  logic signed [31:0] mem_se [DEPTH];
  logic signed [31:0] mem_nw [DEPTH];
  logic signed [31:0] mem_ne [DEPTH];

  ggbs_div #(.N(ggbs_pkg::DIV_N), .D(ggbs_pkg::DIV_D)) u_div_row (
    .clk       (clk),
    .dividend  ({1'b0, q_item.dlat, 16'h0}),
    .divisor   ({1'b0, rstep}),
    .quotient  (quo_r),
    .remainder ()
  );

  ggbs_div #(.N(ggbs_pkg::DIV_N), .D(ggbs_pkg::DIV_D)) u_div_col (
    .clk       (clk),
    .dividend  ({q_item.dlon, 16'h0}),
    .divisor   (cstep),
    .quotient  (quo_c),
    .remainder ()
  );

  ggbs_div #(.N(ggbs_pkg::MOD_N), .D(CCW)) u_mod_col (
    .clk       (clk),
    .dividend  (quo_c[ggbs_pkg::DIV_N-1:16]),
    .divisor   (cols),
    .quotient  (),
    .remainder (mod_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= ggbs_pkg::DIV_N; i++) begin
        a_val[i] <= 1'b0;
      end
      for (int i = 1; i <= ggbs_pkg::MOD_N; i++) begin
        b_val[i] <= 1'b0;
      end
      c_val <= 1'b0;
      s_val <= 1'b0;
      m_val <= 1'b0;
      l1_val <= 1'b0;
      l2_val <= 1'b0;
      l3_val <= 1'b0;
    end else begin
      a_val[1] <= q_valid;
      for (int i = 2; i <= ggbs_pkg::DIV_N; i++) begin
        a_val[i] <= a_val[i-1];
      end
      b_val[1] <= a_val[ggbs_pkg::DIV_N];
      for (int i = 2; i <= ggbs_pkg::MOD_N; i++) begin
        b_val[i] <= b_val[i-1];
      end
      c_val <= b_val[ggbs_pkg::MOD_N];
      s_val <= c_val;
      m_val <= s_val;
      l1_val <= m_val;
      l2_val <= l1_val;
      l3_val <= l2_val;
    end
  end

  always_ff @(posedge clk) begin
    a_pl[1] <= q_item.pl;
    for (int i = 2; i <= ggbs_pkg::DIV_N; i++) begin
      a_pl[i] <= a_pl[i-1];
    end
    b_d[1].pl <= a_pl[ggbs_pkg::DIV_N];
    b_d[1].roff <= quo_r[RO_W-1:0];
    b_d[1].coff <= quo_c[CO_W-1:0];
    for (int i = 2; i <= ggbs_pkg::MOD_N; i++) begin
      b_d[i] <= b_d[i-1];
    end
  end

  always_comb begin
    bl_t bq;
    logic [RCW-1:0] rraw;
    logic [RCW-1:0] rlim;
    logic [RCW-1:0] brow_c;
    logic [CCW-1:0] craw;
    logic [CCW-1:0] clim;
    logic [CCW-1:0] bcol_c;
    logic [CCW-1:0] e1;
    logic [CCW-1:0] ecol_c;
    bq = b_d[ggbs_pkg::MOD_N];
    rraw = bq.roff[RO_W-1:16];
    rlim = rows - RCW'(2);
    brow_c = (rraw > rlim) ? rlim : rraw;
    c_next.pl = bq.pl;
    c_next.brow = RW'(brow_c);
    c_next.rfrac = 17'(bq.roff - {brow_c, 16'h0});
    craw = bq.coff[CO_W-1:16];
    clim = cols - CCW'(2);
    if (global_wrap) begin
      bcol_c = mod_rem;
      c_next.cfrac = {1'b0, bq.coff[15:0]};
    end else begin
      bcol_c = (craw > clim) ? clim : craw;
      c_next.cfrac = 17'(bq.coff - {bcol_c, 16'h0});
    end
    e1 = bcol_c + CCW'(1);
    ecol_c = (global_wrap && e1 == cols) ? '0 : e1;
    c_next.bcol = CW'(bcol_c);
    c_next.ecol = CW'(ecol_c);
  end

  always_ff @(posedge clk) begin
    c_k <= c_next;
    s_k <= c_k;
    s_addr <= AW'(c_k.brow * cols);
    n_addr <= AW'(({1'b0, c_k.brow} + 1'b1) * cols);
  end

  always_ff @(posedge clk) begin
    if (s_val && s_k.pl.mode == ggbs_pkg::MODE_LOAD && 32'(s_k.pl.sample_index) < DEPTH) begin
      mem_sw[AW'(s_k.pl.sample_index)] <= s_k.pl.sample_value;
      mem_se[AW'(s_k.pl.sample_index)] <= s_k.pl.sample_value;
      mem_nw[AW'(s_k.pl.sample_index)] <= s_k.pl.sample_value;
      mem_ne[AW'(s_k.pl.sample_index)] <= s_k.pl.sample_value;
    end
    rd_sw <= mem_sw[s_addr + AW'(s_k.bcol)];
    rd_se <= mem_se[s_addr + AW'(s_k.ecol)];
    rd_nw <= mem_nw[n_addr + AW'(s_k.bcol)];
    rd_ne <= mem_ne[n_addr + AW'(s_k.ecol)];
    m_k <= s_k;
  end

  always_ff @(posedge clk) begin
    logic signed [32:0] dlo;
    logic signed [32:0] dhi;
    logic signed [32:0] dv;
    logic signed [51:0] sum_lo;
    logic signed [51:0] sum_hi;
    dlo = 33'(rd_se) - 33'(rd_sw);
    dhi = 33'(rd_ne) - 33'(rd_nw);
    p_lo <= dlo * $signed({1'b0, m_k.cfrac});
    p_hi <= dhi * $signed({1'b0, m_k.cfrac});
    l1_sw <= rd_sw;
    l1_nw <= rd_nw;
    l1_k <= m_k;

    sum_lo = 52'($signed({l1_sw, 16'h0})) + 52'(p_lo) + 52'(ggbs_pkg::HALF_Q);
    sum_hi = 52'($signed({l1_nw, 16'h0})) + 52'(p_hi) + 52'(ggbs_pkg::HALF_Q);
    lower <= sum_lo[47:16];
    upper <= sum_hi[47:16];
    l2_k <= l1_k;

    dv = 33'(upper) - 33'(lower);
    p_v <= dv * $signed({1'b0, l2_k.rfrac});
    l3_lower <= lower;
    l3_k <= l2_k;
  end

  always_ff @(posedge clk) begin
    logic signed [51:0] sum_v;
    logic hit;
    sum_v = 52'($signed({l3_lower, 16'h0})) + 52'(p_v) + 52'(ggbs_pkg::HALF_Q);
    hit = l3_val && l3_k.pl.mode == ggbs_pkg::MODE_QUERY && l3_k.pl.found;
    if (rst) begin
      done <= 1'b0;
      res <= '0;
    end else begin
      done <= l3_val && l3_k.pl.mode == ggbs_pkg::MODE_QUERY;
      res.found <= hit;
      res.blended_value <= hit ? sum_v[47:16] : '0;
      res.base_row <= hit ? 6'(l3_k.brow) : '0;
      res.base_column <= hit ? 6'(l3_k.bcol) : '0;
      res.row_fraction <= hit ? l3_k.rfrac : '0;
      res.column_fraction <= hit ? l3_k.cfrac : '0;
    end
  end

endmodule

@@ sim/tb.sv @@
module tb;

  typedef struct {
    logic mode;
    logic [11:0] sample_index;
    logic signed [31:0] sample_value;
    logic signed [23:0] query_latitude;
    logic signed [25:0] query_longitude;
  } grid_item_t;

  typedef struct {
    longint south;
    longint west;
    longint rstep;
    longint cstep;
    longint rows;
    longint cols;
    longint wrap;
  } grid_cfg_t;

  localparam longint LAT_LO = -5898240;
  localparam longint LAT_HI = 5898240;
  localparam longint LON_LO = -11796480;
  localparam longint LON_HI = 23592959;
  localparam longint CYCLE_LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic mode = 1'b0;
  logic [11:0] sample_index = '0;
  logic signed [31:0] sample_value = '0;
  logic signed [23:0] query_latitude = '0;
  logic signed [25:0] query_longitude = '0;
  logic done;
  logic found;
  logic signed [31:0] blended_value;
  logic [5:0] base_row;
  logic [5:0] base_column;
  logic [16:0] row_fraction;
  logic [16:0] column_fraction;
  logic cfg_write = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [25:0] cfg_data = '0;

  grid_item_t pending_items[$];
  ggbs_pkg::res_t expected_samples[$];
  logic signed [31:0] grid_copy[4096];
  longint m_south, m_west, m_rstep, m_cstep, m_rows, m_cols, m_wrap;
  int mismatches = 0;
  int queries_done = 0;
  int loads_done = 0;
  int phases_done = 0;
  int gap = 0;
  bit quiet = 1'b0;
  bit took = 1'b0;
  longint cycles = 0;

  geo_grid_bilinear_sampler i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .mode(mode),
    .sample_index(sample_index), .sample_value(sample_value),
    .query_latitude(query_latitude), .query_longitude(query_longitude),
    .done(done), .found(found), .blended_value(blended_value),
    .base_row(base_row), .base_column(base_column),
    .row_fraction(row_fraction), .column_fraction(column_fraction),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  function automatic longint clamp_count(longint c);
    if (c < 2) return 2;
    if (c > 64) return 64;
    return c;
  endfunction

  function automatic longint blend(longint a, longint b, longint f);
    longint x;
    x = a * 65536 + (b - a) * f;
    return (x + 32768) >>> 16;
  endfunction

  function automatic ggbs_pkg::res_t interpolate(longint lat, longint lon);
    ggbs_pkg::res_t r;
    longint rows, cols, rs, cs, dlat, dlon, roff, coff, brow, bcol, ecol;
    longint rfrac, cfrac, w, lower, upper, s, n;
    r = '0;
    rows = clamp_count(m_rows);
    cols = clamp_count(m_cols);
    rs = (m_rstep == 0) ? 1 : m_rstep;
    cs = (m_cstep == 0) ? 1 : m_cstep;
    dlat = lat - m_south;
    if (dlat < 0 || dlat > rs * (rows - 1)) return r;
    dlon = (lon - m_west) % ggbs_pkg::TURN_Q16;
    if (dlon < 0) dlon += ggbs_pkg::TURN_Q16;
    if (m_wrap == 0 && dlon > cs * (cols - 1)) return r;
    roff = (dlat * 65536) / rs;
    coff = (dlon * 65536) / cs;
    brow = roff / 65536;
    if (brow > rows - 2) brow = rows - 2;
    rfrac = roff - brow * 65536;
    if (m_wrap != 0) begin
      w = coff % (cols * 65536);
      bcol = (w / 65536) % cols;
      ecol = (bcol + 1) % cols;
      cfrac = w % 65536;
    end else begin
      bcol = coff / 65536;
      if (bcol > cols - 2) bcol = cols - 2;
      ecol = bcol + 1;
      cfrac = coff - bcol * 65536;
    end
    s = brow * cols;
    n = (brow + 1) * cols;
    lower = blend(grid_copy[s + bcol], grid_copy[s + ecol], cfrac);
    upper = blend(grid_copy[n + bcol], grid_copy[n + ecol], cfrac);
    r.found = 1'b1;
    r.blended_value = 32'(blend(lower, upper, rfrac));
    r.base_row = 6'(brow);
    r.base_column = 6'(bcol);
    r.row_fraction = 17'(rfrac);
    r.column_fraction = 17'(cfrac);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    mismatches++;
  endtask

  // accept items, track register writes, check results
  always @(posedge clk) begin
    ggbs_pkg::res_t want;
    cycles <= cycles + 1;
    took <= start && !busy;
    if (!rst && cfg_write) begin
      case (ggbs_pkg::cfg_reg_t'(cfg_index))
        ggbs_pkg::REG_SOUTH_LATITUDE: m_south = longint'($signed(cfg_data[23:0]));
        ggbs_pkg::REG_WEST_LONGITUDE: m_west = longint'($signed(cfg_data[25:0]));
        ggbs_pkg::REG_ROW_STEP: m_rstep = cfg_data[23:0];
        ggbs_pkg::REG_COLUMN_STEP: m_cstep = cfg_data[24:0];
        ggbs_pkg::REG_ROW_COUNT: m_rows = cfg_data[6:0];
        ggbs_pkg::REG_COLUMN_COUNT: m_cols = cfg_data[6:0];
        ggbs_pkg::REG_GLOBAL_WRAP: m_wrap = cfg_data[0];
        default: ;
      endcase
    end
    if (!rst && start && !busy) begin
      if (mode == ggbs_pkg::MODE_LOAD) begin
        grid_copy[sample_index] = sample_value;
        loads_done++;
      end else begin
        expected_samples.push_back(interpolate(query_latitude, query_longitude));
      end
    end
    if (!rst && done) begin
      if (expected_samples.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = expected_samples.pop_front();
        queries_done++;
        if (found !== want.found) report_mismatch("found", found, want.found);
        if (blended_value !== want.blended_value)
          report_mismatch("blended_value", blended_value, want.blended_value);
        if (base_row !== want.base_row) report_mismatch("base_row", base_row, want.base_row);
        if (base_column !== want.base_column)
          report_mismatch("base_column", base_column, want.base_column);
        if (row_fraction !== want.row_fraction)
          report_mismatch("row_fraction", row_fraction, want.row_fraction);
        if (column_fraction !== want.column_fraction)
          report_mismatch("column_fraction", column_fraction, want.column_fraction);
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", expected_samples.size());
      $display("simulation failed");
      $finish;
    end
  end

  // feed items with random idle bursts
  always @(negedge clk) begin
    grid_item_t it;
    if (rst || (start && !took)) begin
    end else if (gap > 0) begin
      gap <= gap - 1;
      start <= 1'b0;
    end else if (pending_items.size() > 0 && !quiet && $urandom_range(0, 11) == 0) begin
      gap <= $urandom_range(1, 19) - 1;
      start <= 1'b0;
    end else if (pending_items.size() > 0) begin
      it = pending_items.pop_front();
      start <= 1'b1;
      mode <= it.mode;
      sample_index <= it.sample_index;
      sample_value <= it.sample_value;
      query_latitude <= it.query_latitude;
      query_longitude <= it.query_longitude;
    end else begin
      start <= 1'b0;
    end
  end

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  task automatic add_load(longint idx, logic signed [31:0] value);
    grid_item_t it;
    it.mode = ggbs_pkg::MODE_LOAD;
    it.sample_index = 12'(idx);
    it.sample_value = value;
    it.query_latitude = 24'($urandom);
    it.query_longitude = 26'($urandom);
    pending_items.push_back(it);
  endtask

  task automatic add_query(longint lat, longint lon);
    grid_item_t it;
    it.mode = ggbs_pkg::MODE_QUERY;
    it.sample_index = 12'($urandom);
    it.sample_value = $urandom;
    it.query_latitude = 24'(clip(lat, LAT_LO, LAT_HI));
    it.query_longitude = 26'(clip(lon, LON_LO, LON_HI));
    pending_items.push_back(it);
  endtask

  task automatic wait_idle();
    while (pending_items.size() > 0 || start) @(posedge clk);
    while (expected_samples.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(ggbs_pkg::cfg_reg_t idx, longint value);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = 26'(value);
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic run_phase(grid_cfg_t g, int nq, bit set_regs);
    longint rows, cols, rs, cs, rmax, cmax, lat, lon;
    if (set_regs) begin
      write_reg(ggbs_pkg::REG_SOUTH_LATITUDE, g.south);
      write_reg(ggbs_pkg::REG_WEST_LONGITUDE, g.west);
      write_reg(ggbs_pkg::REG_ROW_STEP, g.rstep);
      write_reg(ggbs_pkg::REG_COLUMN_STEP, g.cstep);
      write_reg(ggbs_pkg::REG_ROW_COUNT, g.rows);
      write_reg(ggbs_pkg::REG_COLUMN_COUNT, g.cols);
      write_reg(ggbs_pkg::REG_GLOBAL_WRAP, g.wrap);
    end
    rows = clamp_count(g.rows);
    cols = clamp_count(g.cols);
    rs = (g.rstep == 0) ? 1 : g.rstep;
    cs = (g.cstep == 0) ? 1 : g.cstep;
    rmax = rs * (rows - 1);
    cmax = cs * (cols - 1);
    for (longint i = 0; i < rows * cols; i++) begin
      case ($urandom_range(0, 7))
        0: add_load(i, 32'h7fffffff);
        1: add_load(i, 32'h80000000);
        default: add_load(i, $urandom);
      endcase
    end
    add_query(g.south, g.west);
    add_query(g.south + rmax, g.west + cmax);
    add_query(g.south - 1, g.west);
    add_query(g.south + rmax + 1, g.west);
    add_query(g.south, g.west + cmax + 1);
    add_query(g.south + rmax / 2, g.west - 1);
    add_query(g.south + rmax / 2, g.west + ggbs_pkg::TURN_Q16 - 1);
    add_query(LAT_HI, LON_HI);
    add_query(LAT_LO, LON_LO);
    for (int k = 0; k < nq; k++) begin
      case ($urandom_range(0, 9))
        0: add_load($urandom_range(0, rows * cols - 1), $urandom);
        1: add_load($urandom_range(0, 4095), $urandom);
        2: add_query($urandom_range(0, LAT_HI - LAT_LO) + LAT_LO,
                     $urandom_range(0, LON_HI - LON_LO) + LON_LO);
        default: begin
          lat = g.south + longint'($urandom_range(0, 32'(rmax)));
          if (g.wrap != 0 && $urandom_range(0, 1) == 1)
            lon = g.west + longint'($urandom_range(0, ggbs_pkg::TURN_Q16 - 1));
          else
            lon = g.west + longint'($urandom_range(0, 32'(cmax)));
          if ($urandom_range(0, 3) == 0) lon -= ggbs_pkg::TURN_Q16;
          if (lon > LON_HI) lon -= ggbs_pkg::TURN_Q16;
          add_query(lat, lon);
        end
      endcase
    end
    wait_idle();
    phases_done++;
  endtask

  function automatic grid_cfg_t random_grid();
    grid_cfg_t g;
    g.south = longint'($urandom_range(0, LAT_HI - LAT_LO)) + LAT_LO;
    g.west = longint'($urandom_range(0, LON_HI - LON_LO)) + LON_LO;
    g.rstep = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 11796480)
                                          : $urandom_range(1, 262144);
    g.cstep = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 23592960)
                                          : $urandom_range(1, 524288);
    g.rows = $urandom_range(2, 9);
    g.cols = $urandom_range(2, 9);
    g.wrap = $urandom_range(0, 1);
    return g;
  endfunction

  initial begin
    grid_cfg_t g;
    m_south = -5898240; m_west = -11796480; m_rstep = 65536; m_cstep = 65536;
    m_rows = 64; m_cols = 64; m_wrap = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    // probe the register defaults with points just outside the grid and far beyond it
    add_query(-5898240 + 63 * 65536 + 1, -11796480);
    add_query(-5898240, -11796480 + 63 * 65536 + 1);
    add_query(LAT_HI, LON_HI);
    add_query(0, 0);
    wait_idle();
    g = '{-5898240, -11796480, 11796480, 23592960, 2, 2, 0};
    run_phase(g, 60, 1'b1);
    g = '{5898240, 23592959, 0, 0, 0, 1, 1};
    run_phase(g, 60, 1'b1);
    g = '{-5898240, 0, 1, 1, 127, 3, 1};
    run_phase(g, 60, 1'b1);
    g = '{0, -11796480, 196608, 393216, 10, 60, 1};
    run_phase(g, 80, 1'b1);
    for (int p = 0; p < 3; p++) run_phase(random_grid(), 50, 1'b1);
    quiet = 1'b1;
    run_phase(random_grid(), 100, 1'b1);
    $display("covered %0d register settings, %0d loads and %0d queries checked",
             phases_done, loads_done, queries_done);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
